>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk_i edge, off while in reset.
`define GMCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define GMCC_NEVER(lbl, expr, msg) \
  `GMCC_ASSERT(lbl, !(expr), msg)

`endif

>>> rtl/gmcc_pkg.sv
`timescale 1ns / 1ps

package gmcc_pkg;

  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;

  // Size registers and result width.
  localparam int unsigned CFG_W = 7;
  localparam int unsigned LIT_W = 7;
  localparam int unsigned LIT_MAX = (1 << LIT_W) - 1;

  // Configuration register indexes.
  localparam int unsigned REG_NUM_ROWS = 0;
  localparam int unsigned REG_NUM_COLS = 1;

  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Run lengths reach the full row or column length.
  localparam int unsigned RUN_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned RUN_W = $clog2(RUN_MAX + 1);
  localparam int unsigned SUM_W = RUN_W + 1;

  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = ((LIT_W + 7) / 8) * 8;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;     // start of a new grid
    logic spread;    // one relaxation step of the horizontal runs
    logic vert;      // close the row into the column state
    logic last_row;  // row being closed is the bottom row
    logic reduce;    // fold maxima toward cell 0
  } cell_ctrl_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] vmax);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > vmax) begin
      r = vmax;
    end
    return r;
  endfunction

endpackage

>>> rtl/gmcc_cell.sv
`timescale 1ns / 1ps

// One column of the grid: horizontal runs by neighbor relaxation,
// vertical segment tracking, and a running maximum.
module gmcc_cell import gmcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             blk_i,
  input  logic [RUN_W-1:0] left_run_i,
  input  logic [RUN_W-1:0] right_run_i,
  input  logic [LIT_W-1:0] right_best_i,
  output logic [RUN_W-1:0] left_run_o,
  output logic [RUN_W-1:0] right_run_o,
  output logic [LIT_W-1:0] best_o
);

  logic [RUN_W-1:0] lrun_q, rrun_q, up_q, hmax_q;
  logic [LIT_W-1:0] best_q;

  logic [SUM_W-1:0] hseg_wide;
  logic [RUN_W-1:0] hseg;
  logic [RUN_W-1:0] up_inc;
  logic [RUN_W-1:0] hmax_new;
  logic [RUN_W-1:0] seg_h, seg_v;
  logic [SUM_W-1:0] seg_sum;
  logic [LIT_W-1:0] cand;
  logic             cand_vld;

  always_comb begin
    hseg_wide = SUM_W'(lrun_q) + SUM_W'(rrun_q) - SUM_W'(1);
    hseg      = hseg_wide[RUN_W-1:0];
    up_inc    = up_q + RUN_W'(1);
    hmax_new  = (hseg > hmax_q) ? hseg : hmax_q;
    // blocked cell closes the segment above it; bottom row closes its own
    if (blk_i) begin
      seg_h    = hmax_q;
      seg_v    = up_q;
      cand_vld = (up_q != '0);
    end else begin
      seg_h    = hmax_new;
      seg_v    = up_inc;
      cand_vld = ctrl_i.last_row;
    end
    seg_sum = SUM_W'(seg_h) + SUM_W'(seg_v) - SUM_W'(1);
    cand    = (seg_sum > SUM_W'(LIT_MAX)) ? LIT_W'(LIT_MAX) : seg_sum[LIT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrun_q <= '0;
      rrun_q <= '0;
      up_q   <= '0;
      hmax_q <= '0;
      best_q <= '0;
    end else begin
      if (ctrl_i.clear) begin
        // runs and column state restart from zero for the new grid
        lrun_q <= '0;
        rrun_q <= '0;
        up_q   <= '0;
        hmax_q <= '0;
        best_q <= '0;
      end else begin
        if (ctrl_i.spread) begin
          lrun_q <= blk_i ? '0 : left_run_i + RUN_W'(1);
          rrun_q <= blk_i ? '0 : right_run_i + RUN_W'(1);
        end
        if (ctrl_i.vert) begin
          if (blk_i) begin
            up_q   <= '0;
            hmax_q <= '0;
          end else begin
            up_q   <= up_inc;
            hmax_q <= hmax_new;
          end
          if (cand_vld && (cand > best_q)) begin
            best_q <= cand;
          end
        end
        if (ctrl_i.reduce && (right_best_i > best_q)) begin
          best_q <= right_best_i;
        end
      end
    end
  end

  assign left_run_o  = lrun_q;
  assign right_run_o = rrun_q;
  assign best_o      = best_q;

endmodule

>>> rtl/grid_max_cross_coverage_top.sv
`timescale 1ns / 1ps
// Largest lamp coverage on a binary obstacle grid.
// Input stream: one cell per request in raster order, s_axis_tdata[0] = blocked.
// Output stream: one result per grid, m_axis_tdata[6:0] = max_lit, i.e. the
//   largest left+right+up+down-3 over free cells (0 if all cells blocked).
// APB: num_rows at 0x0, num_cols at 0x4 (1..64; 0 acts as 1, above 64 as 64).
//   Any register write restarts loading at cell 0.
// Timing: a row of C cells loads at one per cycle while s_axis_tvalid is high;
//   then the column chain relaxes the horizontal runs (ST_SPREAD) and folds the
//   row into the per-column vertical state (ST_VERT) before the next row loads.
//   After the bottom row, ST_REDUCE folds the column maxima into cell 0 and
//   ST_DONE loads the result into the output register.
// s_axis_tready is high only while a row is loading.
// Reset: sizes return to 64x64, loading restarts at cell 0, no result pending.
// Stall: the result sits in the output register; the next grid loads
//   meanwhile and its result waits in the chain until the register frees.
module grid_max_cross_coverage_top import gmcc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] blocked, rest zero
  // stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [6:0] max_lit, rest zero
  // APB configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SPREAD,
    ST_VERT,
    ST_REDUCE,
    ST_DONE
  } state_e;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] num_rows_q, num_cols_q;
  logic [CFG_W-1:0] rows_eff, cols_eff;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= CFG_W'(MAX_ROWS);
      num_cols_q <= CFG_W'(MAX_COLS);
    end else if (cfg_wr) begin
      case (paddr[2])
        1'(REG_NUM_ROWS): num_rows_q <= pwdata[CFG_W-1:0];
        1'(REG_NUM_COLS): num_cols_q <= pwdata[CFG_W-1:0];
        default:          num_rows_q <= num_rows_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      1'(REG_NUM_ROWS): prdata = {{(32-CFG_W){1'b0}}, num_rows_q};
      1'(REG_NUM_COLS): prdata = {{(32-CFG_W){1'b0}}, num_cols_q};
      default:          prdata = '0;
    endcase
  end

  assign rows_eff = clamp_size(num_rows_q, CFG_W'(MAX_ROWS));
  assign cols_eff = clamp_size(num_cols_q, CFG_W'(MAX_COLS));

  // ---------------- sequencer ----------------
  state_e           st_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [COL_W-1:0] cnt_q;
  logic             out_vld_q;
  logic [LIT_W-1:0] out_q;
  logic [MAX_COLS-1:0] row_bits_q;

  logic             in_acc;
  logic             out_free;
  logic             last_col, last_step, last_row;
  logic             load_out;
  cell_ctrl_t       ctrl;
  logic [LIT_W-1:0] best_w [MAX_COLS];

  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign out_free  = ~out_vld_q | m_axis_tready;
  assign last_col  = (CFG_W'(col_q) == cols_eff - CFG_W'(1));
  assign last_step = (CFG_W'(cnt_q) == cols_eff - CFG_W'(1));
  assign last_row  = (CFG_W'(row_q) == rows_eff - CFG_W'(1));
  assign load_out  = (st_q == ST_DONE) & out_free;

  always_comb begin
    ctrl          = '0;
    ctrl.clear    = load_out | cfg_wr;
    ctrl.spread   = (st_q == ST_SPREAD);
    ctrl.vert     = (st_q == ST_VERT);
    ctrl.last_row = last_row;
    ctrl.reduce   = (st_q == ST_REDUCE);
  end

  // current row of obstacle bits, filled as cells arrive
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_bits_q[col_q] <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_LOAD;
      row_q     <= '0;
      col_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
        out_q     <= best_w[0];
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_wr) begin
        // a register write drops any partly loaded grid
        st_q  <= ST_LOAD;
        row_q <= '0;
        col_q <= '0;
        cnt_q <= '0;
      end else begin
        case (st_q)
          ST_LOAD: begin
            if (in_acc) begin
              if (last_col) begin
                col_q <= '0;
                cnt_q <= '0;
                st_q  <= ST_SPREAD;
              end else begin
                col_q <= col_q + COL_W'(1);
              end
            end
          end
          ST_SPREAD: begin
            cnt_q <= cnt_q + COL_W'(1);
            if (last_step) begin
              st_q <= ST_VERT;
            end
          end
          ST_VERT: begin
            cnt_q <= '0;
            if (last_row) begin
              row_q <= '0;
              st_q  <= ST_REDUCE;
            end else begin
              row_q <= row_q + ROW_W'(1);
              st_q  <= ST_LOAD;
            end
          end
          ST_REDUCE: begin
            cnt_q <= cnt_q + COL_W'(1);
            if (last_step) begin
              st_q <= ST_DONE;
            end
          end
          ST_DONE: begin
            if (out_free) begin
              st_q <= ST_LOAD;
            end
          end
          default: st_q <= ST_LOAD;
        endcase
      end
    end
  end

  assign s_axis_tready = (st_q == ST_LOAD);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

  // ---------------- column cell chain ----------------
  logic [RUN_W-1:0] lrun_w [MAX_COLS];
  logic [RUN_W-1:0] rrun_w [MAX_COLS];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    logic [RUN_W-1:0] left_in, right_in;
    logic [LIT_W-1:0] rbest_in;
    logic             blk;

    if (c == 0) begin : g_lend
      assign left_in = '0;
    end else begin : g_lmid
      assign left_in = lrun_w[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_rend
      assign right_in = '0;
      assign rbest_in = '0;
    end else begin : g_rmid
      assign right_in = rrun_w[c+1];
      assign rbest_in = best_w[c+1];
    end

    // columns beyond the grid width behave as obstacles
    assign blk = row_bits_q[c] | (CFG_W'(c) >= cols_eff);

    gmcc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .blk_i        (blk),
      .left_run_i   (left_in),
      .right_run_i  (right_in),
      .right_best_i (rbest_in),
      .left_run_o   (lrun_w[c]),
      .right_run_o  (rrun_w[c]),
      .best_o       (best_w[c])
    );
  end

  // ---------------- assertions ----------------
  `GMCC_NEVER(a_col_in_range, (st_q == ST_LOAD) && (CFG_W'(col_q) >= cols_eff),
              "column index beyond grid width while loading")
  `GMCC_NEVER(a_row_in_range, (st_q != ST_DONE) && (CFG_W'(row_q) >= rows_eff),
              "row index beyond grid height")
  `GMCC_NEVER(a_no_overwrite, load_out && out_vld_q && !m_axis_tready,
              "result register overwritten before being taken")
  `GMCC_ASSERT(a_result_source, $rose(m_axis_tvalid) |-> $past(st_q == ST_DONE),
               "result appeared without finishing a grid")

endmodule
